[design/jsu_pkg.sv]
// Shared types, character codes and the UTF-8 encoder for the JSON string unescaper.
// Used by jsu_front, jsu_queue, jsu_back and json_string_unescape_utf8_core.
// No dependencies.
package jsu_pkg;

    // Command queue geometry
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // Parser modes
    typedef enum logic [3:0] {
        M_IDLE = 4'd0,
        M_BODY = 4'd1,
        M_ESC  = 4'd2,
        M_HEX0 = 4'd3,
        M_HEX1 = 4'd4,
        M_HEX2 = 4'd5,
        M_HEX3 = 4'd6,
        M_BSL  = 4'd7,
        M_U    = 4'd8,
        M_LOW0 = 4'd9,
        M_LOW1 = 4'd10,
        M_LOW2 = 4'd11,
        M_LOW3 = 4'd12
    } t_mode;

    // Result kinds; on a command K_DATA means no closing result
    typedef enum logic [1:0] {
        K_DATA  = 2'd0,
        K_DONE  = 2'd1,
        K_ERROR = 2'd2
    } t_kind;

    // One classified input byte: up to four content bytes and an optional closing result
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      nbytes;
        t_kind           term;
    } t_cmd;

    // Character codes
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6e;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Return {valid, value} for an ASCII hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    // Encode a code point as 1 to 4 UTF-8 bytes, first byte in slot 0
    function automatic t_cmd utf8_encode(input logic [20:0] cp);
        t_cmd c;
        c      = '0;
        c.term = K_DATA;
        if (cp <= 21'h7f) begin
            c.bytes[0] = cp[7:0];
            c.nbytes   = 3'd1;
        end else if (cp <= 21'h7ff) begin
            c.bytes[0] = {3'b110, cp[10:6]};
            c.bytes[1] = {2'b10, cp[5:0]};
            c.nbytes   = 3'd2;
        end else if (cp <= 21'hffff) begin
            c.bytes[0] = {4'b1110, cp[15:12]};
            c.bytes[1] = {2'b10, cp[11:6]};
            c.bytes[2] = {2'b10, cp[5:0]};
            c.nbytes   = 3'd3;
        end else begin
            c.bytes[0] = {5'b11110, cp[20:18]};
            c.bytes[1] = {2'b10, cp[17:12]};
            c.bytes[2] = {2'b10, cp[11:6]};
            c.bytes[3] = {2'b10, cp[5:0]};
            c.nbytes   = 3'd4;
        end
        return c;
    endfunction

endpackage

[design/jsu_front.sv]
// Front end: parses one raw byte per transfer and turns it into a command.
// Depends on jsu_pkg; feeds jsu_queue.
module jsu_front import jsu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_text,
    input  logic       i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    t_mode       r_mode, n_mode;
    logic [15:0] r_hex, n_hex;
    logic [9:0]  r_hi, n_hi;

    logic        accept;
    logic        err;
    logic        term;
    logic [4:0]  hd;
    logic [15:0] acc;
    t_cmd        cmd;

    assign accept = i_push && !i_full;

    // Hold parser state between transfers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_hex  <= '0;
            r_hi   <= '0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_hex  <= n_hex;
            r_hi   <= n_hi;
        end
    end

    // Classify the byte and build its command
    always_comb begin
        n_mode = r_mode;
        n_hex  = r_hex;
        n_hi   = r_hi;
        cmd    = '0;
        cmd.term = K_DATA;
        err    = 1'b0;
        term   = 1'b0;
        hd     = hex_digit(i_in_byte);
        acc    = {r_hex[11:0], hd[3:0]};

        case (r_mode)
            M_BODY: begin
                if (i_in_byte == CH_QUOTE) begin
                    cmd.term = K_DONE;
                    term     = 1'b1;
                end else if (i_in_byte < CH_SPACE) begin
                    err = 1'b1;
                end else if (i_in_byte == CH_BSL) begin
                    n_mode = M_ESC;
                end else begin
                    cmd.bytes[0] = i_in_byte;
                    cmd.nbytes   = 3'd1;
                end
            end
            M_ESC: begin
                n_mode     = M_BODY;
                cmd.nbytes = 3'd1;
                case (i_in_byte)
                    CH_QUOTE, CH_BSL, CH_SLASH: cmd.bytes[0] = i_in_byte;
                    CH_B: cmd.bytes[0] = 8'h08;
                    CH_F: cmd.bytes[0] = 8'h0c;
                    CH_N: cmd.bytes[0] = 8'h0a;
                    CH_R: cmd.bytes[0] = 8'h0d;
                    CH_T: cmd.bytes[0] = 8'h09;
                    CH_U: begin
                        cmd.nbytes = 3'd0;
                        n_hex      = '0;
                        n_mode     = M_HEX0;
                    end
                    default: begin
                        cmd.nbytes = 3'd0;
                        err        = 1'b1;
                    end
                endcase
            end
            M_HEX0, M_HEX1, M_HEX2, M_LOW0, M_LOW1, M_LOW2: begin
                if (!hd[4]) begin
                    err = 1'b1;
                end else begin
                    n_hex = acc;
                    case (r_mode)
                        M_HEX0:  n_mode = M_HEX1;
                        M_HEX1:  n_mode = M_HEX2;
                        M_HEX2:  n_mode = M_HEX3;
                        M_LOW0:  n_mode = M_LOW1;
                        M_LOW1:  n_mode = M_LOW2;
                        default: n_mode = M_LOW3;
                    endcase
                end
            end
            M_HEX3: begin
                if (!hd[4]) begin
                    err = 1'b1;
                end else begin
                    n_hex = acc;
                    if (acc inside {[16'hd800:16'hdbff]}) begin
                        // high surrogate: wait for the low half
                        n_hi   = acc[9:0];
                        n_mode = M_BSL;
                    end else if (acc inside {[16'hdc00:16'hdfff]}) begin
                        err = 1'b1;
                    end else begin
                        cmd    = utf8_encode({5'd0, acc});
                        n_mode = M_BODY;
                    end
                end
            end
            M_LOW3: begin
                if (!hd[4]) begin
                    err = 1'b1;
                end else begin
                    n_hex = acc;
                    if (acc inside {[16'hdc00:16'hdfff]}) begin
                        // join the pair: 0x10000 + (high << 10) + low
                        cmd    = utf8_encode({11'h040 + {1'b0, r_hi}, acc[9:0]});
                        n_mode = M_BODY;
                    end else begin
                        err = 1'b1;
                    end
                end
            end
            M_BSL: begin
                if (i_in_byte == CH_BSL) begin
                    n_mode = M_U;
                end else begin
                    err = 1'b1;
                end
            end
            M_U: begin
                if (i_in_byte == CH_U) begin
                    n_hex  = '0;
                    n_mode = M_LOW0;
                end else begin
                    err = 1'b1;
                end
            end
            default: begin
                // idle: expect the opening quote
                if (i_in_byte == CH_QUOTE) begin
                    n_mode = M_BODY;
                end else begin
                    err = 1'b1;
                end
            end
        endcase

        // Early end of text
        if (!term && !err && i_end_of_text) begin
            err = 1'b1;
        end
        if (err) begin
            cmd.term = K_ERROR;
            term     = 1'b1;
        end
        if (term) begin
            n_mode = M_IDLE;
        end
    end

    // Drop commands that carry no result
    assign o_push = accept && (cmd.nbytes != 3'd0 || cmd.term != K_DATA);
    assign o_cmd  = cmd;

    a_push_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_cmd.nbytes != 3'd0 || o_cmd.term != K_DATA))
        else $error("empty command pushed");
    a_term_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_cmd.term != K_DATA) |=> r_mode == M_IDLE)
        else $error("parser not idle after closing result");
    a_nbytes_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> o_cmd.nbytes <= 3'd4)
        else $error("command byte count out of range");

endmodule

[design/jsu_queue.sv]
// Short command queue between the parser front end and the result back end.
// Depends on jsu_pkg.
module jsu_queue import jsu_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_head
);

    t_cmd           r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QCW-1:0] r_count;

    // Store incoming commands
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QAW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QAW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCW'(1);
            end
        end
    end

    assign o_full  = (r_count == QCW'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rp];

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCW'(QDEPTH))
        else $error("queue count overflow");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_count == $past(r_count) + QCW'(1))
        else $error("queue count did not advance on push");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != QCW'(QDEPTH) && r_count != '0) |-> r_wp != r_rp)
        else $error("queue pointers out of step with count");

endmodule

[design/jsu_back.sv]
// Back end: walks each queued command and presents one result per cycle while commands wait and results are popped.
// Depends on jsu_pkg; reads the head of jsu_queue.
module jsu_back import jsu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_empty,
    input  t_cmd       i_head,
    input  logic       i_pop,
    output logic       o_q_pop,
    output logic       o_empty,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_kind,
    output logic       o_last
);

    logic [2:0] r_pos;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    t_kind      r_out_kind;
    logic       r_out_last;

    logic       ld;
    logic       is_byte;
    logic       last_res;

    // Load the output register when it is free or being drained
    assign ld      = !i_q_empty && (!r_out_valid || i_pop);
    assign is_byte = (r_pos < i_head.nbytes);
    assign last_res = is_byte ?
        ((r_pos == i_head.nbytes - 3'd1) && (i_head.term == K_DATA)) : 1'b1;
    assign o_q_pop = ld && last_res;

    // Step through the head command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (ld) begin
                r_pos       <= last_res ? 3'd0 : r_pos + 3'd1;
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the result payload
    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_out_byte <= is_byte ? i_head.bytes[r_pos[1:0]] : 8'h00;
            r_out_kind <= is_byte ? K_DATA : i_head.term;
            r_out_last <= last_res;
        end
    end

    assign o_empty    = !r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_kind     = r_out_kind;
    assign o_last     = r_out_last;

    a_term_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind != K_DATA) |-> r_out_last)
        else $error("closing result not marked last");
    a_pos_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> r_pos == 3'd0)
        else $error("position not cleared after command");
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= 3'd4)
        else $error("position beyond command length");

endmodule

[design/json_string_unescape_utf8_core.sv]
// Top level of the JSON string unescaper: front end, command queue, back end.
// Depends on jsu_pkg, jsu_front, jsu_queue, jsu_back.
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+------------------------------------
//  input    | push / full          | i_in_byte[7:0], i_end_of_text
//  result   | pop / empty          | o_out_byte[7:0], o_kind[1:0], o_last
//
// A byte is parsed in the cycle it is taken; its command is written to the queue, and its
// results then pass one per cycle through the output register while they are popped.
// Sustained rate is one byte per cycle while each byte gives at most one result and results
// are popped every cycle; the back end emits one result per cycle, so a byte with more results holds it back.
// The four-entry command queue decouples the two sides; full rises when it fills.
// Reset is synchronous, active low, and returns the parser to idle with the queue empty.
module json_string_unescape_utf8_core import jsu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_text,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_kind,
    output logic       o_last
);

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    t_cmd q_in;
    t_cmd q_head;

    // Parse incoming bytes
    jsu_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_in_byte     (i_in_byte),
        .i_end_of_text (i_end_of_text),
        .i_full        (q_full),
        .o_push        (q_push),
        .o_cmd         (q_in)
    );

    // Buffer commands
    jsu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // Emit results
    jsu_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_head     (q_head),
        .i_pop      (pop),
        .o_q_pop    (q_pop),
        .o_empty    (empty),
        .o_out_byte (o_out_byte),
        .o_kind     (o_kind),
        .o_last     (o_last)
    );

    assign full = q_full;

endmodule

[bench/unescape_check_pkg.sv]
`timescale 1ns / 100ps
// Expected-result tracking for the JSON string unescaper testbench: a parser model that
// turns each accepted raw byte into the UTF-8, done and error results it should cause.
// Depends on jsu_pkg for the parser modes, result kinds and character codes.
package unescape_check_pkg;
    import jsu_pkg::*;

    typedef struct {
        logic [7:0] b;
        t_kind      k;
        logic       l;
    } t_utf8_result;

    class unescape_tracker;
        t_mode        mode;
        logic [15:0]  hex_acc;
        logic [9:0]   high_bits;
        t_utf8_result due_results[$];
        int           mismatch_count;

        function new();
            mode           = M_IDLE;
            hex_acc        = '0;
            high_bits      = '0;
            mismatch_count = 0;
        endfunction

        function void add(logic [7:0] b, t_kind k);
            t_utf8_result r;
            r.b = b;
            r.k = k;
            r.l = 1'b0;
            due_results.insert(due_results.size(), r);
        endfunction

        // Split a code point into its UTF-8 byte sequence
        function void add_code_point(logic [20:0] cp);
            if (cp < 21'h80) begin
                add(cp[7:0], K_DATA);
            end else if (cp < 21'h800) begin
                add(8'hc0 | 8'(cp[10:6]), K_DATA);
                add(8'h80 | 8'(cp[5:0]), K_DATA);
            end else if (cp < 21'h10000) begin
                add(8'he0 | 8'(cp[15:12]), K_DATA);
                add(8'h80 | 8'(cp[11:6]), K_DATA);
                add(8'h80 | 8'(cp[5:0]), K_DATA);
            end else begin
                add(8'hf0 | 8'(cp[20:18]), K_DATA);
                add(8'h80 | 8'(cp[17:12]), K_DATA);
                add(8'h80 | 8'(cp[11:6]), K_DATA);
                add(8'h80 | 8'(cp[5:0]), K_DATA);
            end
        endfunction

        // Advance the parser by one accepted byte and queue what it produces
        function void take_byte(logic [7:0] c, logic eot);
            t_mode      m;
            logic       closed;
            logic       fault;
            int         first;
            logic [4:0] digit;
            m      = mode;
            closed = 1'b0;
            fault  = 1'b0;
            first  = due_results.size();
            digit  = '0;
            case (m)
                M_BODY: begin
                    if (c == CH_QUOTE) begin
                        add(8'h00, K_DONE);
                        closed = 1'b1;
                    end else if (c < CH_SPACE) begin
                        fault = 1'b1;
                    end else if (c == CH_BSL) begin
                        m = M_ESC;
                    end else begin
                        add(c, K_DATA);
                    end
                end
                M_ESC: begin
                    m = M_BODY;
                    case (c)
                        CH_QUOTE, CH_BSL, CH_SLASH: add(c, K_DATA);
                        CH_B: add(8'h08, K_DATA);
                        CH_F: add(8'h0c, K_DATA);
                        CH_N: add(8'h0a, K_DATA);
                        CH_R: add(8'h0d, K_DATA);
                        CH_T: add(8'h09, K_DATA);
                        CH_U: begin
                            hex_acc = '0;
                            m       = M_HEX0;
                        end
                        default: fault = 1'b1;
                    endcase
                end
                M_HEX0, M_HEX1, M_HEX2, M_HEX3, M_LOW0, M_LOW1, M_LOW2, M_LOW3: begin
                    // letters A-F and a-f share the low nibble pattern 1..6
                    if (c >= 8'h30 && c <= 8'h39) begin
                        digit = {1'b1, c[3:0]};
                    end else if ((c >= 8'h41 && c <= 8'h46) ||
                                 (c >= 8'h61 && c <= 8'h66)) begin
                        digit = {1'b1, c[3:0] + 4'd9};
                    end
                    if (!digit[4]) begin
                        fault = 1'b1;
                    end else begin
                        hex_acc = {hex_acc[11:0], digit[3:0]};
                        if (m == M_HEX3) begin
                            if (hex_acc >= 16'hd800 && hex_acc <= 16'hdbff) begin
                                high_bits = hex_acc[9:0];
                                m         = M_BSL;
                            end else if (hex_acc >= 16'hdc00 && hex_acc <= 16'hdfff) begin
                                fault = 1'b1;
                            end else begin
                                add_code_point({5'd0, hex_acc});
                                m = M_BODY;
                            end
                        end else if (m == M_LOW3) begin
                            if (hex_acc < 16'hdc00 || hex_acc > 16'hdfff) begin
                                fault = 1'b1;
                            end else begin
                                add_code_point(21'h10000 +
                                               {1'b0, high_bits, hex_acc[9:0]});
                                m = M_BODY;
                            end
                        end else begin
                            m = t_mode'(m + 4'd1);
                        end
                    end
                end
                M_BSL: begin
                    if (c == CH_BSL) m = M_U;
                    else fault = 1'b1;
                end
                M_U: begin
                    if (c == CH_U) begin
                        hex_acc = '0;
                        m       = M_LOW0;
                    end else begin
                        fault = 1'b1;
                    end
                end
                default: begin
                    if (c == CH_QUOTE) m = M_BODY;
                    else fault = 1'b1;
                end
            endcase
            // text that runs out before the closing quote is an error too
            if (!closed && !fault && eot) fault = 1'b1;
            if (fault) add(8'h00, K_ERROR);
            if (closed || fault) m = M_IDLE;
            mode = m;
            if (due_results.size() > first) due_results[$].l = 1'b1;
        endfunction

        task report(string msg);
            $display("%0t ns: %s", $time, msg);
            mismatch_count++;
        endtask

        // Compare one accepted result with the oldest one outstanding
        task check_result(logic [7:0] b, logic [1:0] k, logic l);
            t_utf8_result exp_r;
            if (due_results.size() == 0) begin
                report($sformatf("result byte %h kind %0d last %b with nothing outstanding",
                                 b, k, l));
            end else begin
                exp_r = due_results.pop_front();
                if (b !== exp_r.b || k !== exp_r.k || l !== exp_r.l) begin
                    report($sformatf({"got byte %h kind %0d last %b, ",
                                      "wanted byte %h kind %0d last %b"},
                                     b, k, l, exp_r.b, exp_r.k, exp_r.l));
                end
            end
        endtask
    endclass

endpackage

[bench/json_string_unescape_utf8_core_tb.sv]
`timescale 1ns / 100ps
// Testbench for json_string_unescape_utf8_core: feeds quoted JSON text, well formed and
// broken, and checks every result. Depends on jsu_pkg and unescape_check_pkg.
module json_string_unescape_utf8_core_tb;
    import jsu_pkg::*;
    import unescape_check_pkg::*;

    typedef struct packed {
        logic [7:0] b;
        logic       eot;
    } t_text_item;

    localparam int PHASE_ITEMS = 135;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       push     = 1'b0;
    logic [7:0] in_byte  = 8'h00;
    logic       eot      = 1'b0;
    logic       pop      = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last;

    int              push_idle_pct = 38;
    int              pop_idle_pct  = 74;
    t_text_item      text_q[$];
    unescape_tracker tracker = new();

    always #2 clk = ~clk;

    json_string_unescape_utf8_core i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .push         (push),
        .full         (full),
        .i_in_byte    (in_byte),
        .i_end_of_text(eot),
        .empty        (empty),
        .pop          (pop),
        .o_out_byte   (out_byte),
        .o_kind       (kind),
        .o_last       (last)
    );

    function automatic void put(logic [7:0] b, logic e = 1'b0);
        text_q.insert(text_q.size(), {b, e});
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] nib);
        if (nib < 4'd10) return 8'h30 + 8'(nib);
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
    endfunction

    function automatic logic is_hex(logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic is_escape_letter(logic [7:0] c);
        return c inside {CH_QUOTE, CH_BSL, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U};
    endfunction

    // Any byte that passes through the string body as itself
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do c = 8'($urandom_range(32, 255)); while (c == CH_QUOTE || c == CH_BSL);
        return c;
    endfunction

    function automatic void put_unicode(logic [15:0] v);
        put(CH_BSL);
        put(CH_U);
        for (int i = 3; i >= 0; i--) put(hex_char(v[i*4 +: 4]));
    endfunction

    // One piece of valid string content
    function automatic void put_token();
        logic [15:0] v;
        case ($urandom_range(0, 9))
            4: begin
                put(CH_BSL);
                case ($urandom_range(0, 7))
                    0: put(CH_QUOTE);
                    1: put(CH_BSL);
                    2: put(CH_SLASH);
                    3: put(CH_B);
                    4: put(CH_F);
                    5: put(CH_N);
                    6: put(CH_R);
                    default: put(CH_T);
                endcase
            end
            5: put_unicode(16'($urandom_range(0, 'h7f)));
            6: put_unicode(16'($urandom_range('h80, 'h7ff)));
            7: begin
                // skip over the surrogate block
                v = 16'($urandom_range('h800, 'hf7ff));
                if (v >= 16'hd800) v = v + 16'h0800;
                put_unicode(v);
            end
            8, 9: begin
                if ($urandom_range(0, 3) == 0) begin
                    put_unicode($urandom_range(0, 1) ? 16'hd800 : 16'hdbff);
                    put_unicode($urandom_range(0, 1) ? 16'hdc00 : 16'hdfff);
                end else begin
                    put_unicode(16'($urandom_range('hd800, 'hdbff)));
                    put_unicode(16'($urandom_range('hdc00, 'hdfff)));
                end
            end
            default: put(plain_char());
        endcase
    endfunction

    // Mostly well-formed strings; the rest open with a stray byte, end in one kind of fault or end in noise
    function automatic void add_random_string();
        int          fault_sel;
        logic [7:0]  c;
        logic [15:0] v;
        fault_sel = ($urandom_range(0, 99) < 75) ? -1 : int'($urandom_range(0, 7));
        if (fault_sel == 0) begin
            do c = 8'($urandom); while (c == CH_QUOTE);
            put(c);
        end
        put(CH_QUOTE);
        repeat ($urandom_range(0, fault_sel < 0 ? 8 : 3)) put_token();
        case (fault_sel)
            1: put(8'($urandom_range(0, 31)));
            2: begin
                put(CH_BSL);
                do c = 8'($urandom); while (is_escape_letter(c));
                put(c);
            end
            3: begin
                put(CH_BSL);
                put(CH_U);
                repeat ($urandom_range(0, 3)) put(hex_char(4'($urandom)));
                do c = 8'($urandom); while (is_hex(c));
                put(c);
            end
            4: put_unicode(16'($urandom_range('hdc00, 'hdfff)));
            5: begin
                put_unicode(16'($urandom_range('hd800, 'hdbff)));
                case ($urandom_range(0, 2))
                    0: put(plain_char());
                    1: begin
                        put(CH_BSL);
                        do c = 8'($urandom); while (c == CH_U);
                        put(c);
                    end
                    default: begin
                        do v = 16'($urandom); while (v >= 16'hdc00 && v <= 16'hdfff);
                        put_unicode(v);
                    end
                endcase
            end
            6: put($urandom_range(0, 1) ? plain_char() : CH_BSL, 1'b1);
            7: repeat ($urandom_range(1, 6)) put(8'($urandom), $urandom_range(0, 7) == 0);
            default: put(CH_QUOTE, $urandom_range(0, 3) == 0);
        endcase
    endfunction

    // Offer one byte, with random idle cycles first, and hold it until the transfer
    task automatic send_item(t_text_item it);
        while ($urandom_range(0, 99) < push_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        in_byte <= it.b;
        eot     <= it.eot;
        do @(posedge clk); while (full);
        tracker.take_byte(it.b, it.eot);
    endtask

    task automatic send_text();
        foreach (text_q[i]) send_item(text_q[i]);
    endtask

    // Result side: check each transfer, then decide whether to pop next cycle
    initial begin
        forever begin
            @(posedge clk);
            if (pop && !empty) tracker.check_result(out_byte, kind, last);
            pop <= rst_n && ($urandom_range(0, 99) >= pop_idle_pct);
        end
    end

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: stray byte in idle, control byte, unknown escape 'q',
        // extreme surrogate pair closed on the last byte, early end of text
        put(8'h00);
        put(CH_QUOTE);
        put(8'hff);
        put(8'h1f);
        put(CH_QUOTE);
        put(CH_BSL);
        put(8'h71);
        put(CH_QUOTE);
        put_unicode(16'hd800);
        put_unicode(16'hdfff);
        put(CH_QUOTE, 1'b1);
        put(CH_QUOTE);
        put(8'h41, 1'b1);
        send_text();

        // Hold the sender until everything outstanding has drained
        while (tracker.due_results.size() != 0) begin
            push <= 1'b0;
            @(posedge clk);
        end

        for (int phase = 0; phase < 3; phase++) begin
            push_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 74 : 0;
            pop_idle_pct  = (phase == 0) ? 74 : (phase == 1) ? 38 : 0;
            text_q.delete();
            while (text_q.size() < PHASE_ITEMS) add_random_string();
            send_text();
        end
        push <= 1'b0;

        while (tracker.due_results.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
        if (tracker.mismatch_count == 0 && tracker.due_results.size() == 0) begin
            $display("json_string_unescape_utf8_core: match");
        end else begin
            $display("json_string_unescape_utf8_core: mismatch");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("json_string_unescape_utf8_core: mismatch");
        $finish;
    end

endmodule

[files.f]
design/jsu_pkg.sv
design/jsu_front.sv
design/jsu_queue.sv
design/jsu_back.sv
design/json_string_unescape_utf8_core.sv
bench/unescape_check_pkg.sv
bench/json_string_unescape_utf8_core_tb.sv
